### src/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = 2'd3;

    localparam logic CMD_TEMP = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    typedef struct packed {
        logic        command;
        logic [19:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic               zero_divisor;
    } out_item_t;

    // 16-bit slice k of a register, sign-extended to 32 bits
    function automatic logic [31:0] slice_s(input logic [63:0] r, input int k);
        logic [15:0] v;
        v = r[16*k +: 16];
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

### src/ptc_mul.sv
`default_nettype none
// Shared 32x32 multiplier, low 32 bits of the product, one registered stage.
module ptc_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] p
);
    logic [31:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

### src/ptc_div.sv
`default_nettype none
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
module ptc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic      [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[31]};
        trial    = shifted - {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### src/pressure_temperature_compensation_core.sv
`default_nettype none
// Integer compensation of a barometric sensor's raw 20-bit readings. A
// temperature transfer (command 0) updates the held fine temperature and
// returns degC x100; a pressure transfer (command 1) uses the held fine
// temperature and returns Pa, or 0 with zero_divisor set when the divisor
// term is zero. All arithmetic wraps at 32 bits. One shared registered
// 32x32 multiplier is sequenced through every product (each passes an
// operand-select state, then a result-use state), and a one-bit-per-cycle
// divider serves the pressure quotient. A temperature result takes four
// products, a pressure result ten products plus the divide, and a
// zero-divisor pressure result six products. in_stall is high whenever
// the core is not idle, up to the cycle in which the result is taken.
// The output register holds the result until out_stall drops. Coefficients
// must be written through cfg_we/cfg_index/cfg_data only while idle; the
// core does not enforce this. Every 2-bit index selects a register.
module pressure_temperature_compensation_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire ptc_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output ptc_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ptc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,   // operands presented to multiplier
        S_USE  = 6'b000100,   // product available, consume it
        S_DIV  = 6'b001000,
        S_TAIL = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;     // microstep within the item
    logic        cmd_reg;
    logic [19:0] adc_reg;
    logic [47:0] tcoef_reg;
    logic [63:0] plow_reg, phigh_reg;
    logic [15:0] p9_reg;
    logic [31:0] fine_reg;
    logic [31:0] x_reg, y_reg, z_reg;   // scratch
    logic [31:0] ma, mb, prod;
    logic        div_start, div_busy;
    logic [31:0] div_dend, div_q;
    out_item_t   out_reg;
    logic        zero_reg;

    ptc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));
    ptc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dend),
                   .divisor(x_reg), .busy(div_busy), .quotient(div_q));

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, tcoef_reg[15:0]};
    assign t2 = slice_s({16'd0, tcoef_reg}, 1);
    assign t3 = slice_s({16'd0, tcoef_reg}, 2);
    assign p1 = {16'd0, plow_reg[15:0]};
    assign p2 = slice_s(plow_reg, 1);
    assign p3 = slice_s(plow_reg, 2);
    assign p4 = slice_s(plow_reg, 3);
    assign p5 = slice_s(phigh_reg, 0);
    assign p6 = slice_s(phigh_reg, 1);
    assign p7 = slice_s(phigh_reg, 2);
    assign p8 = slice_s(phigh_reg, 3);
    assign p9 = {{16{p9_reg[15]}}, p9_reg};

    logic [31:0] adc32, v1t;
    assign adc32 = {12'd0, adc_reg};
    // pressure v1 = (fine >> 1) - 64000
    assign v1t = sra32(fine_reg, 1) - 32'd64000;

    // multiplier operand select per microstep
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (cmd_reg == CMD_TEMP)
        begin
            case (step_reg)
                4'd0: begin ma = (adc32 >> 3) - (t1 << 1); mb = t2; end
                4'd1: begin ma = (adc32 >> 4) - t1; mb = (adc32 >> 4) - t1; end
                4'd2: begin ma = sra32(y_reg, 12); mb = t3; end
                4'd3: begin ma = x_reg; mb = 32'd5; end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                4'd0: begin ma = sra32(v1t, 2); mb = sra32(v1t, 2); end
                4'd1: begin ma = sra32(y_reg, 11); mb = p6; end     // y = sq
                4'd2: begin ma = v1t; mb = p5; end
                4'd3: begin ma = p3; mb = sra32(y_reg, 13); end
                4'd4: begin ma = p2; mb = v1t; end
                4'd5: begin ma = 32'd32768 + x_reg; mb = p1; end
                4'd6: begin ma = z_reg; mb = 32'd3125; end
                4'd7: begin ma = x_reg >> 3; mb = x_reg >> 3; end   // x = p
                4'd8: begin ma = p9; mb = y_reg >> 13; end
                4'd9: begin ma = x_reg >> 2; mb = p8; end
                default: ;
            endcase
        end
    end

    logic        zero_next;
    logic [31:0] x_next, y_next, z_next, fine_next, val_next;
    logic        div_go;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        fine_next = fine_reg;
        zero_next = zero_reg;
        val_next = out_reg.value;
        div_go = 1'b0;
        div_dend = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                    step_next = '0;
                    zero_next = 1'b0;
                end
            end
            S_MUL: state_next = S_USE;
            S_USE:
            begin
                state_next = S_MUL;
                step_next = step_reg + 4'd1;
                if (cmd_reg == CMD_TEMP)
                begin
                    case (step_reg)
                        4'd0: x_next = sra32(prod, 11);
                        4'd1: y_next = prod;
                        4'd2:
                        begin
                            x_next = x_reg + sra32(prod, 14);
                            fine_next = x_reg + sra32(prod, 14);
                        end
                        default:
                        begin
                            val_next = sra32(prod + 32'd128, 8);
                            state_next = S_OUT;
                        end
                    endcase
                end
                else
                begin
                    case (step_reg)
                        4'd0: y_next = prod;                      // sq
                        4'd1: z_next = prod;                      // v2 partial
                        4'd2: z_next = sra32(z_reg + (prod << 1), 2) + (p4 << 16);
                        4'd3: x_next = sra32(prod, 3);
                        4'd4: x_next = sra32(x_reg + sra32(prod, 1), 18);
                        4'd5:
                        begin
                            x_next = sra32(prod, 15);
                            z_next = (32'd1048576 - adc32) - sra32(z_reg, 12);
                            if (sra32(prod, 15) == 32'd0)
                            begin
                                zero_next = 1'b1;
                                val_next = '0;
                                state_next = S_OUT;
                            end
                        end
                        4'd6:
                        begin
                            z_next = prod;
                            state_next = S_DIV;
                            div_go = 1'b1;
                            div_dend = prod[31] ? prod : (prod << 1);
                        end
                        4'd7: y_next = prod;
                        4'd8: y_next = sra32(prod, 12);
                        default:
                        begin
                            val_next = x_reg + sra32(y_reg + sra32(prod, 13) + p7, 4);
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV: state_next = S_TAIL;
            S_TAIL:
            begin
                if (!div_busy)
                begin
                    x_next = z_reg[31] ? (div_q << 1) : div_q;   // p
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign div_start = div_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fine_reg  <= '0;
            tcoef_reg <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            p9_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fine_reg  <= fine_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP_COEF:  tcoef_reg <= cfg_data[47:0];
                    REG_PRESS_LOW:  plow_reg  <= cfg_data;
                    REG_PRESS_HIGH: phigh_reg <= cfg_data;
                    REG_PRESS_NINE: p9_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg <= in_data.command;
            adc_reg <= in_data.raw_sample;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
        out_reg.value <= val_next;
        out_reg.kind <= cmd_reg;
        out_reg.zero_divisor <= zero_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;
endmodule
`default_nettype wire
